### src/qr_alphanumeric_data_encoder_defines.svh
`ifndef QR_ALPHANUMERIC_DATA_ENCODER_DEFINES_SVH
`define QR_ALPHANUMERIC_DATA_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QR_ADE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qr_ade: implication failed");

// Next-cycle implication, disabled while reset is high.
`define QR_ADE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qr_ade: next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define QR_ADE_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("qr_ade: reset behavior failed");

`endif

### src/qr_ade_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qr_ade_pkg;

   localparam int DATA_CODEWORDS_DEF = 22;
   localparam int MAX_SYMBOLS_DEF    = 29;

   localparam int STORE_DEPTH = 32;
   localparam int ADDR_W      = 5;
   localparam int SYM_W       = 7;
   localparam int CNT_W       = 6;
   localparam int ACC_W       = 24;
   localparam int ACC_CNT_W   = 5;
   localparam int PROD_W      = 13;

   localparam logic [SYM_W-1:0] BAD_VALUE  = 7'd100;
   localparam logic [3:0]       MODE_ALNUM = 4'b0010;
   localparam logic [7:0]       PAD_BYTE_A = 8'hEC;
   localparam logic [7:0]       PAD_BYTE_B = 8'h11;
   localparam logic [PROD_W-1:0] PAIR_MULT = 13'd45;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_LONG = 2'd2;

   typedef struct packed {
      logic accept;
      logic rd_a;
      logic rd_b;
      logic app_hdr;
      logic app_pair;
      logic app_tail;
      logic app_term;
      logic emit_data;
      logic emit_err;
   } qr_ade_cmd_type;

   typedef struct packed {
      logic out_free;
      logic acc_full;
      logic pair_left;
      logic one_left;
      logic too_long;
      logic last_byte;
   } qr_ade_sts_type;

   function automatic logic [SYM_W-1:0] symbol_value(input logic [7:0] code);
      logic [7:0] u;
      logic [SYM_W-1:0] v;
      u = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         u = code - 8'd32;
      end
      if (u >= 8'h30 && u <= 8'h39) begin
         v = SYM_W'(u - 8'h30);
      end else if (u >= 8'h41 && u <= 8'h5A) begin
         v = SYM_W'(u - 8'd55);
      end else begin
         case (u)
            8'h20:   v = 7'd36;
            8'h24:   v = 7'd37;
            8'h25:   v = 7'd38;
            8'h2A:   v = 7'd39;
            8'h2B:   v = 7'd40;
            8'h2D:   v = 7'd41;
            8'h2E:   v = 7'd42;
            8'h2F:   v = 7'd43;
            8'h3A:   v = 7'd44;
            default: v = BAD_VALUE;
         endcase
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### src/qr_ade_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module qr_ade_dp import qr_ade_pkg::*; #(
   parameter int DATA_CODEWORDS = DATA_CODEWORDS_DEF,
   parameter int MAX_SYMBOLS    = MAX_SYMBOLS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire qr_ade_cmd_type cmd,
   output qr_ade_sts_type      sts,
   input  wire logic [7:0]     req_char_code,
   input  wire logic           req_last_char,
   input  wire logic           rsp_ready,
   output logic                rsp_valid,
   output logic [7:0]          rsp_codeword,
   output logic                rsp_last_codeword,
   output logic [1:0]          rsp_status
);

   localparam int BCNT_W = (DATA_CODEWORDS > 1) ? $clog2(DATA_CODEWORDS) : 1;

   logic [SYM_W-1:0] store_mem [STORE_DEPTH];
   logic [SYM_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 bad_ff, bad_in;
   logic [CNT_W-1:0]     len_ff;
   logic [1:0]           status_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [PROD_W-1:0]    a45_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_CNT_W-1:0] acc_cnt_ff;
   logic [BCNT_W-1:0]    byte_cnt_ff;
   logic                 pad_sel_ff;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_codeword_ff;
   logic                 rsp_last_codeword_ff;
   logic [1:0]           rsp_status_ff;

   logic [SYM_W-1:0]  sym;
   logic              sym_bad;
   logic [PROD_W-1:0] pair_sum;
   logic [ACC_W-1:0]  field;
   logic [ADDR_W-1:0] rd_addr;
   logic              acc_full;
   logic              last_byte;
   logic [7:0]        data_byte;
   logic [CNT_W:0]    idx_ext;
   logic [CNT_W:0]    len_ext;

   assign sym      = symbol_value(req_char_code);
   assign sym_bad  = (sym == BAD_VALUE);
   assign count_in = (count_ff == {CNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;
   assign bad_in   = bad_ff | sym_bad;

   assign idx_ext   = {1'b0, idx_ff};
   assign len_ext   = {1'b0, len_ff};
   assign acc_full  = (acc_cnt_ff >= ACC_CNT_W'(8));
   assign last_byte = (byte_cnt_ff == BCNT_W'(DATA_CODEWORDS - 1));
   assign pair_sum  = a45_ff + {{(PROD_W-SYM_W){1'b0}}, rd_data_ff};
   assign rd_addr   = cmd.rd_b ? ADDR_W'(idx_ff + 1'b1) : idx_ff[ADDR_W-1:0];
   assign data_byte = acc_full ? acc_ff[ACC_W-1 -: 8]
                               : (pad_sel_ff ? PAD_BYTE_B : PAD_BYTE_A);

   // Left-aligned field, shifted into place behind the bits already held.
   always_comb begin
      field = '0;
      if (cmd.app_hdr) begin
         field = {MODE_ALNUM, 3'b000, len_ff, 11'b0};
      end else if (cmd.app_pair) begin
         field = {pair_sum[10:0], 13'b0};
      end else if (cmd.app_tail) begin
         field = {rd_data_ff[5:0], 18'b0};
      end
   end

   always_comb begin
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.acc_full  = acc_full;
      sts.pair_left = (idx_ext + 1'b1) < len_ext;
      sts.one_left  = idx_ff < len_ff;
      sts.too_long  = count_in > CNT_W'(MAX_SYMBOLS);
      sts.last_byte = last_byte;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[count_ff[ADDR_W-1:0]] <= sym;
      end
      if (cmd.rd_a || cmd.rd_b) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (req_last_char) begin
               count_ff <= '0;
               bad_ff   <= 1'b0;
            end else begin
               count_ff <= count_in;
               bad_ff   <= bad_in;
            end
         end
         if (cmd.emit_data || cmd.emit_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_last_char) begin
         len_ff      <= count_in;
         status_ff   <= bad_in ? STATUS_BAD : STATUS_OK;
         idx_ff      <= '0;
         acc_ff      <= '0;
         acc_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         pad_sel_ff  <= 1'b0;
      end
      if (cmd.rd_b) begin
         a45_ff <= PROD_W'(rd_data_ff) * PAIR_MULT;
      end
      if (cmd.app_hdr) begin
         acc_ff     <= acc_ff | field;
         acc_cnt_ff <= ACC_CNT_W'(13);
      end
      if (cmd.app_pair) begin
         acc_ff     <= acc_ff | (field >> acc_cnt_ff);
         acc_cnt_ff <= acc_cnt_ff + ACC_CNT_W'(11);
         idx_ff     <= idx_ff + CNT_W'(2);
      end
      if (cmd.app_tail) begin
         acc_ff     <= acc_ff | (field >> acc_cnt_ff);
         acc_cnt_ff <= acc_cnt_ff + ACC_CNT_W'(6);
      end
      if (cmd.app_term) begin
         // four terminator zeros, then zero fill up to the byte boundary
         acc_cnt_ff <= (acc_cnt_ff + ACC_CNT_W'(11)) & ~ACC_CNT_W'(7);
      end
      if (cmd.emit_data) begin
         byte_cnt_ff <= byte_cnt_ff + 1'b1;
         if (acc_full) begin
            acc_ff     <= acc_ff << 8;
            acc_cnt_ff <= acc_cnt_ff - ACC_CNT_W'(8);
         end else begin
            pad_sel_ff <= !pad_sel_ff;
         end
      end
      if (cmd.emit_data) begin
         rsp_codeword_ff      <= data_byte;
         rsp_last_codeword_ff <= last_byte;
         rsp_status_ff        <= status_ff;
      end else if (cmd.emit_err) begin
         rsp_codeword_ff      <= '0;
         rsp_last_codeword_ff <= 1'b1;
         rsp_status_ff        <= STATUS_LONG;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_codeword      = rsp_codeword_ff;
   assign rsp_last_codeword = rsp_last_codeword_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

### src/qr_ade_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module qr_ade_ctrl import qr_ade_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last_char,
   output logic                req_ready,
   input  wire qr_ade_sts_type sts,
   output qr_ade_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_HDR,
      ST_SEL,
      ST_RDB,
      ST_PAIR,
      ST_TAIL,
      ST_TERM,
      ST_PAD
   } state_type;

   state_type state_ff, state_in;
   logic      drain;

   assign drain     = sts.acc_full && sts.out_free;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last_char) begin
                  state_in = sts.too_long ? ST_ERR : ST_HDR;
               end
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_HDR: begin
            cmd.app_hdr = 1'b1;
            state_in    = ST_SEL;
         end
         ST_SEL: begin
            // read the next symbol while earlier bytes drain out
            cmd.rd_a      = 1'b1;
            cmd.emit_data = drain;
            if (sts.pair_left) begin
               state_in = ST_RDB;
            end else if (sts.one_left) begin
               state_in = ST_TAIL;
            end else begin
               state_in = ST_TERM;
            end
         end
         ST_RDB: begin
            cmd.rd_b      = 1'b1;
            cmd.emit_data = drain;
            state_in      = ST_PAIR;
         end
         ST_PAIR: begin
            if (sts.acc_full) begin
               cmd.emit_data = sts.out_free;
            end else begin
               cmd.app_pair = 1'b1;
               state_in     = ST_SEL;
            end
         end
         ST_TAIL: begin
            if (sts.acc_full) begin
               cmd.emit_data = sts.out_free;
            end else begin
               cmd.app_tail = 1'b1;
               state_in     = ST_TERM;
            end
         end
         ST_TERM: begin
            if (sts.acc_full) begin
               cmd.emit_data = sts.out_free;
            end else begin
               cmd.app_term = 1'b1;
               state_in     = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.emit_data = sts.out_free;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // the final codeword ends the message whatever is still pending
      if (cmd.emit_data && sts.last_byte) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/qr_alphanumeric_data_encoder.sv
// Channel   Ports                                         Direction  Transaction
// req       req_valid/req_ready, req_char_code,           in         one message character
//           req_last_char
// rsp       rsp_valid/rsp_ready, rsp_codeword,            out        one data codeword
//           rsp_last_codeword, rsp_status
//
// Characters are taken one per cycle while the block is idle.
// After the last character the codewords come out of a 24-bit bit accumulator
// fed from the single read port of the 32-entry symbol store: each character pair
// takes two reads and one append, and full bytes drain while pairs are read; an
// overlong message gives one result. Synchronous active-high reset; an rsp stall
// holds the remaining codewords, and the next append once the accumulator holds a
// full byte, until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module qr_alphanumeric_data_encoder import qr_ade_pkg::*; #(
   parameter int DATA_CODEWORDS = DATA_CODEWORDS_DEF,
   parameter int MAX_SYMBOLS    = MAX_SYMBOLS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_last_char,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_codeword,
   output logic            rsp_last_codeword,
   output logic [1:0]      rsp_status
);

   qr_ade_cmd_type cmd;
   qr_ade_sts_type sts;

   qr_ade_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_char (req_last_char),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   qr_ade_dp #(
      .DATA_CODEWORDS (DATA_CODEWORDS),
      .MAX_SYMBOLS    (MAX_SYMBOLS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_char_code     (req_char_code),
      .req_last_char     (req_last_char),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_codeword      (rsp_codeword),
      .rsp_last_codeword (rsp_last_codeword),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

### src/qr_ade_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "qr_alphanumeric_data_encoder_defines.svh"

module qr_ade_chk import qr_ade_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_char_code,
   input wire logic       req_last_char,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_codeword,
   input wire logic       rsp_last_codeword,
   input wire logic [1:0] rsp_status
);

   logic req_xact;
   logic rsp_hold;
   logic [7:0] unused_code;

   assign req_xact    = req_valid && req_ready;
   assign rsp_hold    = rsp_valid && !rsp_ready;
   assign unused_code = req_char_code;

   `QR_ADE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_codeword) && $stable(rsp_last_codeword) && $stable(rsp_status))

   // an overlong message ends in a single zero codeword
   `QR_ADE_ASSERT_IMP(a_long_form, clock, reset, rsp_valid && rsp_status == STATUS_LONG, rsp_last_codeword && rsp_codeword == 8'h00 && unused_code == req_char_code)

   // encoding, or the overlong error, starts right after the last character: no new transaction then
   `QR_ADE_ASSERT_NXT(a_busy_after_last, clock, reset, req_xact && req_last_char, !req_ready)

   `QR_ADE_ASSERT_NXT_ALL(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind qr_alphanumeric_data_encoder qr_ade_chk u_qr_ade_chk (.*);

`default_nettype wire
